FILE: rtl/cosine_similarity_accumulator_top_defines.svh
// Assertion macros for the cosine similarity accumulator.
// Included by the top level; depends on nothing else.
`ifndef COSINE_SIMILARITY_ACCUMULATOR_TOP_DEFINES_SVH
`define COSINE_SIMILARITY_ACCUMULATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CSA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csa: assertion failed");
`define CSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csa: assertion failed");
`else
`define CSA_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define CSA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/csa_pkg.sv
// Shared constants and controller/datapath interface types for the
// cosine similarity accumulator. No dependencies.
package csa_pkg;

   localparam int ELEMENT_WIDTH_DEF = 16;
   localparam int ACC_W             = 48;   // accumulator width
   localparam int SIM_W             = 16;   // Q1.15 result
   localparam int FRAC_BITS         = 15;
   localparam int PROD_W            = 2 * ACC_W;          // norm_a * norm_b
   localparam int REM_W             = ACC_W + 3;          // square root remainder
   localparam int NUM_W             = ACC_W + FRAC_BITS;  // dividend width
   localparam int Q_W               = SIM_W + 1;          // kept quotient bits
   localparam int MUL_STEPS         = ACC_W;
   localparam int SQRT_STEPS        = ACC_W;
   localparam int DIV_STEPS         = NUM_W;
   localparam int CNT_W             = 6;

   localparam logic [SIM_W-1:0] SIM_MAX = {1'b0, {(SIM_W-1){1'b1}}};
   localparam logic [SIM_W-1:0] SIM_MIN = {1'b1, {(SIM_W-1){1'b0}}};

   typedef struct packed {
      logic capture;    // input transfer this cycle
      logic load_mul;
      logic step_mul;
      logic load_sqrt;
      logic step_sqrt;
      logic load_div;
      logic step_div;
      logic load_rsp;   // register the result and clear the accumulators
   } csa_cmd_type;

   typedef struct packed {
      logic zero_norm;
   } csa_status_type;

endpackage

FILE: rtl/cosine_similarity_accumulator_top.sv
// Cosine similarity accumulator, top level.
// Input stream: req_tdata carries element_a (low) and element_b, both signed
// Q4.12 at ELEMENT_WIDTH bits; req_tlast marks the final pair of a vector.
// Pairs are taken one per cycle while req_tready is high; each adds a*b, a*a
// and b*b into 48-bit saturating accumulators.
// After the transfer that carries req_tlast, req_tready stays low while the
// result is computed: the sums settle, then the shift-add product of the
// norms, the square root and the divide run in turn; a zero norm skips those
// three units.
// The result (similarity, Q1.15 saturated, in rsp_tdata; zero_norm in
// rsp_tuser) sits in an output register, and the block goes back to taking
// pairs while it waits. If the receiver stalls, the next result is held back
// until the previous one has been transferred.
// Reset clears the accumulators and any pending result.
// Depends on csa_pkg, csa_ctrl, csa_dp and the defines header.
`include "cosine_similarity_accumulator_top_defines.svh"

module cosine_similarity_accumulator_top #(
   parameter int ELEMENT_WIDTH = csa_pkg::ELEMENT_WIDTH_DEF,
   localparam int DATA_W = ((2 * ELEMENT_WIDTH + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [DATA_W-1:0]           req_tdata,   // element_a, element_b, zero fill
   input  logic                        req_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [csa_pkg::SIM_W-1:0]   rsp_tdata,   // similarity
   output logic [0:0]                  rsp_tuser    // zero_norm
);

   csa_pkg::csa_cmd_type              cmd;
   csa_pkg::csa_status_type           status;
   logic signed [ELEMENT_WIDTH-1:0]   element_a;
   logic signed [ELEMENT_WIDTH-1:0]   element_b;
   logic                              zero_norm;

   assign element_a = req_tdata[ELEMENT_WIDTH-1:0];
   assign element_b = req_tdata[2*ELEMENT_WIDTH-1:ELEMENT_WIDTH];
   assign rsp_tuser = zero_norm;

   csa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   csa_dp #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .element_a  (element_a),
      .element_b  (element_b),
      .status     (status),
      .similarity (rsp_tdata),
      .zero_norm  (zero_norm)
   );

   // A final pair stops intake on the following cycle.
   `CSA_ASSERT_NEXT(a_last_stops_intake, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)
   // A zero-norm result always carries a zero similarity.
   `CSA_ASSERT_IMPLIES(a_zero_norm_value, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0)
   // A new result only appears after intake has been stopped.
   `CSA_ASSERT_IMPLIES(a_rsp_after_busy, clock, reset, $rose(rsp_tvalid), $past(!req_tready))

endmodule

FILE: rtl/csa_ctrl.sv
// Sequencing state machine for the cosine similarity accumulator.
// Depends on csa_pkg for the command and status types.
module csa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tlast,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  csa_pkg::csa_status_type status,
   output csa_pkg::csa_cmd_type    cmd
);

   localparam logic [2:0] ST_ACCUM = 3'd0;
   localparam logic [2:0] ST_FLUSH = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_SQRT  = 3'd4;
   localparam logic [2:0] ST_PREP  = 3'd5;
   localparam logic [2:0] ST_DIV   = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]                  state_ff, state_in;
   logic [csa_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        out_valid_ff, out_valid_in;

   assign req_tready = (state_ff == ST_ACCUM);
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      case (state_ff)
         ST_ACCUM: begin
            cmd.capture = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = ST_FLUSH;
            end
         end
         // The last product is added to the accumulators in this cycle.
         ST_FLUSH: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.zero_norm) begin
               state_in = ST_DONE;
            end else begin
               cmd.load_mul = 1'b1;
               cnt_in       = csa_pkg::CNT_W'(csa_pkg::MUL_STEPS - 1);
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.step_mul = 1'b1;
            if (cnt_ff == '0) begin
               cmd.load_sqrt = 1'b1;
               cnt_in        = csa_pkg::CNT_W'(csa_pkg::SQRT_STEPS - 1);
               state_in      = ST_SQRT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_SQRT: begin
            cmd.step_sqrt = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_PREP;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_PREP: begin
            cmd.load_div = 1'b1;
            cnt_in       = csa_pkg::CNT_W'(csa_pkg::DIV_STEPS - 1);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.step_div = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            // Wait until the output register is free or being emptied.
            if (!out_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_rsp) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

FILE: rtl/csa_dp.sv
// Datapath of the cosine similarity accumulator: products, saturating sums,
// shift-add multiplier, bit-serial square root and divider. Uses csa_pkg.
module csa_dp #(
   parameter int ELEMENT_WIDTH = csa_pkg::ELEMENT_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  csa_pkg::csa_cmd_type             cmd,
   input  logic signed [ELEMENT_WIDTH-1:0]  element_a,
   input  logic signed [ELEMENT_WIDTH-1:0]  element_b,
   output csa_pkg::csa_status_type          status,
   output logic [csa_pkg::SIM_W-1:0]        similarity,
   output logic                             zero_norm
);

   localparam int ACC_W = csa_pkg::ACC_W;
   localparam int PW    = 2 * ELEMENT_WIDTH;
   localparam int SW    = ((PW > ACC_W) ? PW : ACC_W) + 1;

   // Adds a product and clamps to the signed accumulator range.
   function automatic logic [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                               input logic signed [PW-1:0] p);
      logic signed [SW-1:0] s;
      begin
         s = SW'(acc) + SW'(p);
         if (s[SW-1:ACC_W-1] == '0 || s[SW-1:ACC_W-1] == '1) begin
            sat_add = s[ACC_W-1:0];
         end else if (s[SW-1]) begin
            sat_add = {1'b1, {(ACC_W-1){1'b0}}};
         end else begin
            sat_add = {1'b0, {(ACC_W-1){1'b1}}};
         end
      end
   endfunction

   logic signed [PW-1:0]           dot_p_ff, dot_p_in, na_p_ff, na_p_in, nb_p_ff, nb_p_in;
   logic                           p_valid_ff;
   logic signed [ACC_W-1:0]        dot_ff, dot_in, na_ff, na_in, nb_ff, nb_in;

   logic [ACC_W-1:0]               mcand_ff, mcand_in, mplier_ff, mplier_in;
   logic [csa_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic [csa_pkg::REM_W-1:0]      rem_ff, rem_in;
   logic [ACC_W-1:0]               root_ff, root_in;
   logic [ACC_W-1:0]               div_ff, div_in;
   logic [csa_pkg::NUM_W-1:0]      num_ff, num_in;
   logic [csa_pkg::Q_W-1:0]        q_ff, q_in;
   logic                           big_ff, big_in;
   logic [csa_pkg::SIM_W-1:0]      sim_ff, sim_in;
   logic                           zero_ff, zero_in;

   logic [ACC_W:0]                 mul_sum;
   logic [csa_pkg::REM_W-1:0]      sq_shift, sq_trial;
   logic [csa_pkg::REM_W:0]        sq_diff;
   logic [ACC_W:0]                 dv_shift;
   logic [ACC_W+1:0]               dv_diff;
   logic [ACC_W-1:0]               mag;
   logic                           neg;

   assign status.zero_norm = (na_ff == '0) || na_ff[ACC_W-1] ||
                             (nb_ff == '0) || nb_ff[ACC_W-1];
   assign similarity = sim_ff;
   assign zero_norm  = zero_ff;

   assign neg = dot_ff[ACC_W-1];
   assign mag = neg ? (ACC_W'(0) - dot_ff) : dot_ff;

   always_comb begin
      dot_p_in = element_a * element_b;
      na_p_in  = element_a * element_a;
      nb_p_in  = element_b * element_b;
   end

   always_comb begin
      dot_in = dot_ff;
      na_in  = na_ff;
      nb_in  = nb_ff;
      if (cmd.load_rsp) begin
         dot_in = '0;
         na_in  = '0;
         nb_in  = '0;
      end else if (p_valid_ff) begin
         dot_in = sat_add(dot_ff, dot_p_ff);
         na_in  = sat_add(na_ff, na_p_ff);
         nb_in  = sat_add(nb_ff, nb_p_ff);
      end
   end

   always_comb begin
      mul_sum  = {1'b0, prod_ff[csa_pkg::PROD_W-1:ACC_W]} +
                 (mplier_ff[0] ? {1'b0, mcand_ff} : '0);
      sq_shift = {rem_ff[csa_pkg::REM_W-3:0], prod_ff[csa_pkg::PROD_W-1 -: 2]};
      sq_trial = {1'b0, root_ff, 2'b01};
      sq_diff  = {1'b0, sq_shift} - {1'b0, sq_trial};
      dv_shift = {rem_ff[ACC_W-1:0], num_ff[csa_pkg::NUM_W-1]};
      dv_diff  = {1'b0, dv_shift} - {2'b00, div_ff};

      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      div_in    = div_ff;
      num_in    = num_ff;
      q_in      = q_ff;
      big_in    = big_ff;
      sim_in    = sim_ff;
      zero_in   = zero_ff;

      if (cmd.load_mul) begin
         mcand_in  = na_ff;
         mplier_in = nb_ff;
         prod_in   = '0;
      end
      if (cmd.step_mul) begin
         prod_in   = {mul_sum, prod_ff[ACC_W-1:1]};
         mplier_in = {1'b0, mplier_ff[ACC_W-1:1]};
      end
      if (cmd.load_sqrt) begin
         rem_in  = '0;
         root_in = '0;
      end
      // One result bit per step, two radicand bits consumed from the top.
      if (cmd.step_sqrt) begin
         prod_in = {prod_ff[csa_pkg::PROD_W-3:0], 2'b00};
         if (!sq_diff[csa_pkg::REM_W]) begin
            rem_in  = sq_diff[csa_pkg::REM_W-1:0];
            root_in = {root_ff[ACC_W-2:0], 1'b1};
         end else begin
            rem_in  = sq_shift;
            root_in = {root_ff[ACC_W-2:0], 1'b0};
         end
      end
      if (cmd.load_div) begin
         div_in = (root_ff == '0) ? ACC_W'(1) : root_ff;
         num_in = {mag, {csa_pkg::FRAC_BITS{1'b0}}} +
                  csa_pkg::NUM_W'(root_ff[ACC_W-1:1]);
         rem_in = '0;
         q_in   = '0;
         big_in = 1'b0;
      end
      // Restoring division; quotient bits above the kept ones only flag overflow.
      if (cmd.step_div) begin
         num_in = {num_ff[csa_pkg::NUM_W-2:0], 1'b0};
         q_in   = {q_ff[csa_pkg::Q_W-2:0], !dv_diff[ACC_W+1]};
         big_in = big_ff | q_ff[csa_pkg::Q_W-1];
         if (!dv_diff[ACC_W+1]) begin
            rem_in = csa_pkg::REM_W'(dv_diff[ACC_W-1:0]);
         end else begin
            rem_in = csa_pkg::REM_W'(dv_shift[ACC_W-1:0]);
         end
      end
      if (cmd.load_rsp) begin
         zero_in = status.zero_norm;
         if (status.zero_norm) begin
            sim_in = '0;
         end else if (neg) begin
            if (big_ff || q_ff > csa_pkg::Q_W'(csa_pkg::SIM_MIN)) begin
               sim_in = csa_pkg::SIM_MIN;
            end else begin
               sim_in = csa_pkg::SIM_W'(0) - q_ff[csa_pkg::SIM_W-1:0];
            end
         end else begin
            if (big_ff || q_ff > csa_pkg::Q_W'(csa_pkg::SIM_MAX)) begin
               sim_in = csa_pkg::SIM_MAX;
            end else begin
               sim_in = q_ff[csa_pkg::SIM_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         dot_ff     <= '0;
         na_ff      <= '0;
         nb_ff      <= '0;
      end else begin
         p_valid_ff <= cmd.capture;
         dot_ff     <= dot_in;
         na_ff      <= na_in;
         nb_ff      <= nb_in;
      end
   end

   always_ff @(posedge clock) begin
      dot_p_ff  <= dot_p_in;
      na_p_ff   <= na_p_in;
      nb_p_ff   <= nb_p_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      div_ff    <= div_in;
      num_ff    <= num_in;
      q_ff      <= q_in;
      big_ff    <= big_in;
      sim_ff    <= sim_in;
      zero_ff   <= zero_in;
   end

endmodule

FILE: sim/cosine_similarity_accumulator_top_tb.sv
// Self-checking testbench for cosine_similarity_accumulator_top.
// Streams element pairs, predicts each Q1.15 similarity with wide-integer
// arithmetic and checks every result transfer. Depends on csa_pkg and the RTL.
module cosine_similarity_accumulator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAIR_W = 32;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 200;
   localparam longint ACC_HI = (longint'(1) <<< (csa_pkg::ACC_W - 1)) - 1;
   localparam longint ACC_LO = -ACC_HI - 1;

   typedef struct {
      logic [csa_pkg::SIM_W-1:0] similarity;
      logic                      zero_norm;
   } similarity_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [PAIR_W-1:0]         req_tdata = '0;   // element_a, element_b
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [csa_pkg::SIM_W-1:0] rsp_tdata;        // similarity
   logic [0:0]                rsp_tuser;        // zero_norm

   // Running sums of the vectors in flight, as the block should hold them.
   longint dot_acc = 0;
   longint norm_a_acc = 0;
   longint norm_b_acc = 0;
   similarity_result_type expected_sims[$];

   int  error_count = 0;
   int  pairs_sent = 0;
   int  vectors_sent = 0;
   int  results_checked = 0;
   int  zero_norm_results = 0;
   int  clipped_results = 0;
   int  idle_cycles = 0;
   int  rsp_hold = 0;
   bit  gaps_on = 1'b0;
   bit  stall_on = 1'b0;

   cosine_similarity_accumulator_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint sat_acc(longint total);
      if (total > ACC_HI) return ACC_HI;
      if (total < ACC_LO) return ACC_LO;
      return total;
   endfunction

   function automatic logic signed [15:0] clip16(int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Rounded dot / floor(sqrt(norm_a * norm_b)) in Q1.15, clipped to 16 bits.
   function automatic logic [csa_pkg::SIM_W-1:0] cosine_q15(longint dot, longint na,
                                                           longint nb);
      logic [95:0] na_w, nb_w, prod, trial_sq;
      logic [47:0] root, trial;
      logic [63:0] mag, quot, divisor;
      na_w = 96'(na);
      nb_w = 96'(nb);
      prod = na_w * nb_w;
      root = '0;
      for (int bit_idx = 47; bit_idx >= 0; bit_idx--) begin
         trial = root | (48'd1 << bit_idx);
         trial_sq = {48'd0, trial} * {48'd0, trial};
         if (trial_sq <= prod) root = trial;
      end
      if (root == 0) root = 48'd1;
      divisor = {16'd0, root};
      mag = (dot < 0) ? -dot : dot;
      quot = ((mag << csa_pkg::FRAC_BITS) + (divisor >> 1)) / divisor;
      if (dot < 0) begin
         if (quot > 64'd32768) return csa_pkg::SIM_MIN;
         return 16'(64'd0 - quot);
      end
      if (quot > 64'd32767) return csa_pkg::SIM_MAX;
      return quot[15:0];
   endfunction

   function automatic void accumulate_pair(logic signed [15:0] elem_a,
                                           logic signed [15:0] elem_b, logic last_pair);
      longint pa, pb;
      similarity_result_type res;
      pa = longint'(elem_a);
      pb = longint'(elem_b);
      dot_acc = sat_acc(dot_acc + pa * pb);
      norm_a_acc = sat_acc(norm_a_acc + pa * pa);
      norm_b_acc = sat_acc(norm_b_acc + pb * pb);
      if (!last_pair) return;
      if (norm_a_acc <= 0 || norm_b_acc <= 0) begin
         res.similarity = '0;
         res.zero_norm = 1'b1;
         zero_norm_results++;
      end else begin
         res.similarity = cosine_q15(dot_acc, norm_a_acc, norm_b_acc);
         res.zero_norm = 1'b0;
         if (res.similarity == csa_pkg::SIM_MAX || res.similarity == csa_pkg::SIM_MIN)
            clipped_results++;
      end
      expected_sims.insert(expected_sims.size(), res);
      vectors_sent++;
      dot_acc = 0;
      norm_a_acc = 0;
      norm_b_acc = 0;
   endfunction

   // Called at a rising edge; returns at the edge where the pair is transferred.
   task automatic send_pair(input logic signed [15:0] elem_a,
                            input logic signed [15:0] elem_b, input logic last_pair);
      int gap;
      gap = 0;
      if (gaps_on && $urandom_range(0, 99) < 40) gap = idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {elem_b, elem_a};
      req_tlast <= last_pair;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accumulate_pair(elem_a, elem_b, last_pair);
      pairs_sent++;
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (expected_sims.size() != 0) @(posedge clock);
   endtask

   task automatic test_single_pairs();
      send_pair(16'sh7fff, 16'sh7fff, 1'b1);
      send_pair(16'sh8000, 16'sh8000, 1'b1);
      send_pair(16'sh8000, 16'sh7fff, 1'b1);
      send_pair(16'sh7fff, 16'sh8000, 1'b1);
      send_pair(0, 0, 1'b1);
      send_pair(0, 5, 1'b1);
      send_pair(5, 0, 1'b1);
      send_pair(1, 1, 1'b1);
      send_pair(-1, 1, 1'b1);
   endtask

   task automatic test_short_vectors();
      // Identical vectors round up to exactly +1.0, which must clip.
      send_pair(1000, 1000, 1'b0);
      send_pair(-2000, -2000, 1'b0);
      send_pair(3000, 3000, 1'b1);
      // Opposite vectors give exactly -1.0.
      send_pair(1000, -1000, 1'b0);
      send_pair(-2000, 2000, 1'b0);
      send_pair(3000, -3000, 1'b1);
      // Orthogonal vectors.
      send_pair(4096, 0, 1'b0);
      send_pair(0, 4096, 1'b1);
      // First vector all zero over several elements.
      send_pair(0, 123, 1'b0);
      send_pair(0, -77, 1'b0);
      send_pair(0, 16'sh8000, 1'b1);
   endtask

   task automatic random_vector(input int len);
      int style;
      logic signed [15:0] ea, eb;
      style = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
         ea = 16'($urandom_range(0, 65535));
         eb = 16'($urandom_range(0, 65535));
         case (style)
            1: begin
               ea = 16'(int'($urandom_range(0, 512)) - 256);
               eb = 16'(int'($urandom_range(0, 512)) - 256);
            end
            2: eb = clip16(int'(ea) + int'($urandom_range(0, 2000)) - 1000);
            3: eb = clip16(-int'(ea) + int'($urandom_range(0, 2000)) - 1000);
            4: ea = 0;
            5: begin
               if ($urandom_range(0, 2) != 0) ea = 0;
               if ($urandom_range(0, 2) != 0) eb = 0;
            end
            6: begin
               case ($urandom_range(0, 4))
                  0: ea = 16'sh8000;
                  1: ea = 16'sh7fff;
                  2: ea = -1;
                  3: ea = 1;
                  default: ea = 0;
               endcase
               eb = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
            end
            default: ;
         endcase
         send_pair(ea, eb, i == len - 1);
      end
   endtask

   task automatic test_random_vectors(input int pair_target);
      int start, r, len;
      start = pairs_sent;
      while (pairs_sent - start < pair_target) begin
         r = $urandom_range(0, 99);
         if (r < 60) len = $urandom_range(1, 8);
         else if (r < 92) len = $urandom_range(9, 32);
         else len = $urandom_range(33, 120);
         random_vector(len);
      end
   endtask

   // Runs of full-scale pairs feed all three sums full-scale products.
   task automatic test_full_scale_runs();
      for (int i = 0; i < 40; i++)
         send_pair(16'sh8000, 16'sh8000, i == 39);
      for (int i = 0; i < 40; i++)
         send_pair(16'sh8000, 16'sh7fff, i == 39);
   endtask

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (!stall_on || $urandom_range(0, 3) != 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         rsp_hold <= idle_length();
      end
   end

   always @(posedge clock) begin : check_result
      similarity_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_sims.size() == 0) begin
            $error("unexpected result transfer: similarity %0d zero_norm %0d",
                   $signed(rsp_tdata), rsp_tuser);
            error_count++;
         end else begin
            want = expected_sims.pop_front();
            results_checked++;
            if (rsp_tdata !== want.similarity) begin
               $error("similarity: expected %0d, got %0d",
                      $signed(want.similarity), $signed(rsp_tdata));
               error_count++;
            end
            if (rsp_tuser[0] !== want.zero_norm) begin
               $error("zero_norm: expected %0d, got %0d", want.zero_norm, rsp_tuser[0]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", expected_sims.size());
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_pairs();
      gaps_on = 1'b1;
      stall_on = 1'b1;
      test_short_vectors();

      test_random_vectors(360);
      wait_until_drained();
      gaps_on = 1'b0;
      stall_on = 1'b0;
      test_random_vectors(170);
      stall_on = 1'b1;
      test_random_vectors(150);
      gaps_on = 1'b1;
      stall_on = 1'b0;
      test_random_vectors(150);

      gaps_on = 1'b0;
      stall_on = 1'b1;
      test_full_scale_runs();

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_sims.size() != 0) begin
         $error("%0d expected results never arrived", expected_sims.size());
         error_count++;
      end

      $display("Streamed %0d element pairs in %0d vectors; checked %0d similarities,",
               pairs_sent, vectors_sent, results_checked);
      $display("%0d of them zero-norm and %0d clipped to full scale; %0d errors.",
               zero_norm_results, clipped_results, error_count);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: cosine_similarity_accumulator_top.f
+incdir+rtl
rtl/csa_pkg.sv
rtl/csa_ctrl.sv
rtl/csa_dp.sv
rtl/cosine_similarity_accumulator_top.sv
sim/cosine_similarity_accumulator_top_tb.sv
